/* rtl/bsm_pkg.sv */
package bsm_pkg;

   localparam int unsigned CRD_W = 32;   // center coordinate, signed Q16.16
   localparam int unsigned RAD_W = 31;   // radius, unsigned Q15.16
   localparam int unsigned DL_W  = 33;   // center delta, signed
   localparam int unsigned MAG_W = 32 + 1;
   localparam int unsigned SQ_W  = 2 * MAG_W - 1;
   localparam int unsigned SUM_W = 66;   // sum of three squares
   localparam int unsigned RT_W  = SUM_W / 2;
   localparam int unsigned REM_W = RT_W + 1;
   localparam int unsigned DEN_W = RT_W + 1;
   localparam int unsigned NUM_W = MAG_W + RAD_W;
   localparam int unsigned QT_W  = RAD_W - 1;

   localparam int unsigned SQ_N   = RT_W;      // root stages, one bit each
   localparam int unsigned DIV_N  = QT_W;      // quotient stages, one bit each
   localparam int unsigned PRE_N  = 3 + SQ_N;  // delta, square, sum, root
   localparam int unsigned POST_N = 1 + DIV_N; // decide, quotient
   localparam int unsigned VLD_N  = PRE_N + POST_N + 1;

   typedef enum logic [1:0] {
      SRC_MERGE = 2'd0,
      SRC_A     = 2'd1,
      SRC_B     = 2'd2
   } src_type;

   typedef struct packed {
      logic [2:0][CRD_W-1:0] a;
      logic [2:0][CRD_W-1:0] b;
      logic [RAD_W-1:0]      ra;
      logic [RAD_W-1:0]      rb;
      logic [2:0][DL_W-1:0]  dl;
   } pre_type;

   typedef struct packed {
      src_type               src;
      logic [2:0][CRD_W-1:0] pick;
      logic [RAD_W-1:0]      radius;
      logic [2:0][CRD_W-1:0] mid;
      logic [2:0]            neg;
   } post_type;

endpackage

/* rtl/bsm_sqrt.sv */
module bsm_sqrt
   import bsm_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [SUM_W-1:0] sum,
   output logic [RT_W-1:0]  root
);

   logic [REM_W-1:0] rem_ff  [SQ_N];
   logic [RT_W-1:0]  root_ff [SQ_N];
   logic [SUM_W-1:0] rad_ff  [SQ_N];

   for (genvar k = 0; k < SQ_N; k++) begin : g_stage
      logic [REM_W-1:0] rem_p;
      logic [RT_W-1:0]  root_p;
      logic [SUM_W-1:0] rad_p;
      logic [REM_W+1:0] rem2;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic             ge;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = sum;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
      end

      // bring down the next bit pair, try root*4+1
      assign rem2  = {rem_p, rad_p[SUM_W-1 -: 2]};
      assign trial = (REM_W+2)'({root_p, 2'b01});
      assign diff  = rem2 - trial;
      assign ge    = rem2 >= trial;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
            root_ff[k] <= {root_p[RT_W-2:0], ge};
            rad_ff[k]  <= {rad_p[SUM_W-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[SQ_N-1];

endmodule

/* rtl/bsm_div.sv */
module bsm_div
   import bsm_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QT_W-1:0]  quot
);

   logic [NUM_W-1:0] rem_ff [DIV_N];
   logic [DEN_W-1:0] den_ff [DIV_N];
   logic [QT_W-1:0]  q_ff   [DIV_N];

   for (genvar j = 0; j < DIV_N; j++) begin : g_stage
      localparam int unsigned SH = DIV_N - 1 - j;
      logic [NUM_W-1:0] rem_p;
      logic [DEN_W-1:0] den_p;
      logic [QT_W-1:0]  q_p;
      logic [NUM_W-1:0] sub;
      logic             ge;

      if (j == 0) begin : g_first
         assign rem_p = num;
         assign den_p = den;
         assign q_p   = '0;
      end else begin : g_next
         assign rem_p = rem_ff[j-1];
         assign den_p = den_ff[j-1];
         assign q_p   = q_ff[j-1];
      end

      // quotient stays below 2^QT_W; the shifted divisor fits in NUM_W bits and never overflows
      assign sub = NUM_W'(den_p) << SH;
      assign ge  = rem_p >= sub;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= ge ? rem_p - sub : rem_p;
            den_ff[j] <= den_p;
            q_ff[j]   <= {q_p[QT_W-2:0], ge};
         end
      end
   end

   assign quot = q_ff[DIV_N-1];

endmodule

/* rtl/bounding_sphere_merge.sv */
// Smallest sphere enclosing two spheres, fully pipelined.
//
// Input channel req_*: one beat carries spheres A and B (centers signed
// Q16.16, radii unsigned Q15.16). Result channel rsp_*: one beat per input
// beat, in order, with the enclosing center and radius in rsp_tdata and in
// rsp_tuser which sphere was returned (merged, A or B).
//
// From an accepted input beat to its result beat the pipeline runs through three
// stages for deltas, squares and their sum, 33 stages of the bit-per-stage
// square root of the squared distance, one decision/multiply stage, 30
// stages of the bit-per-stage divider that scales the center offset, and
// the output register. Throughput is one beat per cycle unless the output stalls.
//
// The whole pipeline advances as one: it moves whenever the output register
// is empty or being taken. When the receiver holds rsp_tready low with a
// result pending, every stage holds and req_tready drops; nothing is lost or
// repeated. Bubbles travel as cleared valid bits.
//
// Reset (synchronous, active high) clears all valid bits; payload registers
// are not reset. There is no configuration and no state between beats.
module bounding_sphere_merge
   import bsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_x[31:0], a_y[63:32], a_z[95:64], a_radius[126:96], b_x[158:127],
   // b_y[190:159], b_z[222:191], b_radius[253:223], zero[255:254]
   input  logic [255:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], out_radius[126:96], zero[127]
   output logic [127:0] rsp_tdata,
   // source[1:0]
   output logic [1:0]   rsp_tuser
);

   function automatic logic [MAG_W-1:0] mag_of(input logic [DL_W-1:0] v);
      return v[DL_W-1] ? MAG_W'(-v) : MAG_W'(v);
   endfunction

   logic adv;
   logic [VLD_N-1:0] vld_ff;

   assign rsp_tvalid = vld_ff[VLD_N-1];
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[VLD_N-2:0], req_tvalid};
      end
   end

   // unpack input beat and take the center deltas
   pre_type pre_in;
   always_comb begin
      pre_in.a[0] = req_tdata[31:0];
      pre_in.a[1] = req_tdata[63:32];
      pre_in.a[2] = req_tdata[95:64];
      pre_in.ra   = req_tdata[126:96];
      pre_in.b[0] = req_tdata[158:127];
      pre_in.b[1] = req_tdata[190:159];
      pre_in.b[2] = req_tdata[222:191];
      pre_in.rb   = req_tdata[253:223];
      for (int i = 0; i < 3; i++) begin
         pre_in.dl[i] = DL_W'($signed(pre_in.b[i])) - DL_W'($signed(pre_in.a[i]));
      end
   end

   // sideband that rides alongside squares, sum and root
   pre_type pre_ff [PRE_N];
   always_ff @(posedge clock) begin
      if (adv) begin
         pre_ff[0] <= pre_in;
         for (int k = 1; k < PRE_N; k++) begin
            pre_ff[k] <= pre_ff[k-1];
         end
      end
   end

   logic [2:0][SQ_W-1:0] sq_ff;
   logic [SUM_W-1:0]     sum_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= SQ_W'(mag_of(pre_ff[0].dl[i]) * mag_of(pre_ff[0].dl[i]));
         end
         sum_ff <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
      end
   end

   logic [RT_W-1:0] cdist;

   bsm_sqrt u_sqrt (
      .clock (clock),
      .en    (adv),
      .sum   (sum_ff),
      .root  (cdist)
   );

   // decide containment, form midpoint, radius and offset numerators
   pre_type  pd;
   post_type post_in;
   logic [RT_W:0]      d_ra;
   logic [RT_W:0]      d_rb;
   logic [RT_W:0]      rsum;
   logic               sel_a;
   logic               sel_b;
   logic               rneg;
   logic [RAD_W-1:0]   rdiff;
   logic [2:0][NUM_W-1:0] num_in;
   logic [CRD_W:0]     csum;

   always_comb begin
      pd    = pre_ff[PRE_N-1];
      d_ra  = (RT_W+1)'(cdist) + (RT_W+1)'(pd.ra);
      d_rb  = (RT_W+1)'(cdist) + (RT_W+1)'(pd.rb);
      rsum  = d_ra + (RT_W+1)'(pd.rb);
      sel_a = (d_rb < (RT_W+1)'(pd.ra)) || (d_ra >= (RT_W+1)'(pd.rb) && cdist == '0);
      sel_b = !sel_a && (d_ra < (RT_W+1)'(pd.rb));
      rneg  = pd.rb < pd.ra;
      rdiff = rneg ? pd.ra - pd.rb : pd.rb - pd.ra;
      csum  = '0;

      if (sel_a) begin
         post_in.src    = SRC_A;
         post_in.pick   = pd.a;
         post_in.radius = pd.ra;
      end else if (sel_b) begin
         post_in.src    = SRC_B;
         post_in.pick   = pd.b;
         post_in.radius = pd.rb;
      end else begin
         post_in.src    = SRC_MERGE;
         post_in.pick   = pd.a;
         // halve and clamp to the radius range
         post_in.radius = (|rsum[RT_W:RAD_W+1]) ? {RAD_W{1'b1}} : rsum[RAD_W:1];
      end

      for (int i = 0; i < 3; i++) begin
         csum           = (CRD_W+1)'($signed(pd.a[i])) + (CRD_W+1)'($signed(pd.b[i]));
         post_in.mid[i] = csum[CRD_W:1];   // floor of half
         post_in.neg[i] = pd.dl[i][DL_W-1] ^ rneg;
         num_in[i]      = NUM_W'(mag_of(pd.dl[i]) * rdiff);
      end
   end

   post_type              post_ff [POST_N];
   logic [2:0][NUM_W-1:0] num_ff;
   logic [DEN_W-1:0]      den_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         post_ff[0] <= post_in;
         num_ff     <= num_in;
         den_ff     <= {cdist, 1'b0};
         for (int k = 1; k < POST_N; k++) begin
            post_ff[k] <= post_ff[k-1];
         end
      end
   end

   logic [2:0][QT_W-1:0] quot;

   for (genvar i = 0; i < 3; i++) begin : g_axis
      bsm_div u_div (
         .clock (clock),
         .en    (adv),
         .num   (num_ff[i]),
         .den   (den_ff),
         .quot  (quot[i])
      );
   end

   // apply signed offset to the midpoint and saturate, or pass the picked center through
   post_type pf;
   logic [2:0][CRD_W-1:0] ctr;
   logic signed [CRD_W+1:0] csat;
   logic signed [CRD_W+1:0] qs;

   always_comb begin
      pf   = post_ff[POST_N-1];
      csat = '0;
      qs   = '0;
      for (int i = 0; i < 3; i++) begin
         qs   = pf.neg[i] ? -(CRD_W+2)'(quot[i]) : (CRD_W+2)'(quot[i]);
         csat = (CRD_W+2)'($signed(pf.mid[i])) + qs;
         if (pf.src != SRC_MERGE) begin
            ctr[i] = pf.pick[i];
         end else if (csat > (CRD_W+2)'(32'sh7FFF_FFFF)) begin
            ctr[i] = {1'b0, {(CRD_W-1){1'b1}}};
         end else if (csat < -(CRD_W+2)'(33'sh0_8000_0000)) begin
            ctr[i] = {1'b1, {(CRD_W-1){1'b0}}};
         end else begin
            ctr[i] = csat[CRD_W-1:0];
         end
      end
   end

   logic [127:0] out_data_ff;
   logic [1:0]   out_user_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {1'b0, pf.radius, ctr[2], ctr[1], ctr[0]};
         out_user_ff <= pf.src;
      end
   end

   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

   // a stall freezes every valid bit in the pipe
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved during stall");

   // an accepted beat occupies the first stage next cycle
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat lost at entry");

   // a merged result never divides by a zero distance
   a_merge_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[PRE_N] && post_ff[0].src == SRC_MERGE |-> den_ff != '0)
      else $error("merge with zero distance");

endmodule
